// File: src/rrpp_pkg.sv
package rrpp_pkg;

  localparam int ANG_W      = 16;
  localparam int DEN_W      = 9;
  localparam int PHASE_W    = 15;
  localparam int DIV_W      = 24;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = DIV_W / DIV_STEP;
  localparam int N_TERMS    = 7;
  localparam int QS_LAT     = 2 + 3 * N_TERMS + 2;
  localparam int PIPE_LAT   = 5 + DIV_STAGES + 1 + QS_LAT + 2;

  localparam logic [PHASE_W-1:0] QTR_TURN    = 15'd16384;
  localparam logic [30:0]        HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0]        ONE_Q30     = 31'd1073741824;
  localparam logic [15:0]        TRIG_SCALE  = 16'd65535;
  localparam logic [17:0]        RECIP_100   = 18'd167773;
  localparam logic [9:0]         ARC_SCALE   = 10'd628;

  typedef enum logic [3:0] {
    SEG_TOP_R  = 4'd0,
    ARC_TR     = 4'd1,
    SEG_RIGHT  = 4'd2,
    ARC_BR     = 4'd3,
    SEG_BOTTOM = 4'd4,
    ARC_BL     = 4'd5,
    SEG_LEFT   = 4'd6,
    ARC_TL     = 4'd7,
    SEG_TOP_L  = 4'd8
  } seg_t;

  typedef struct packed {
    logic       bad;
    logic       is_arc;
    logic [9:0] px;
    logic [9:0] py;
    logic [1:0] quad;
    logic [7:0] rad;
  } side_t;

endpackage

// File: src/rrpp_div.sv
module rrpp_div import rrpp_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [DIV_W-1:0]   num_in,
  input  logic [DEN_W-1:0]   den_in,
  output logic [PHASE_W-1:0] quo_out
);

  logic [DIV_W-1:0] num_w [DIV_STAGES+1];
  logic [DIV_W-1:0] quo_w [DIV_STAGES+1];
  logic [DEN_W:0]   rem_w [DIV_STAGES+1];
  logic [DEN_W-1:0] den_w [DIV_STAGES+1];

  assign num_w[0] = num_in;
  assign quo_w[0] = '0;
  assign rem_w[0] = '0;
  assign den_w[0] = den_in;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stg
    logic [DIV_W-1:0] num_nxt, quo_nxt, num_r, quo_r;
    logic [DEN_W:0]   rem_nxt, rem_r;
    logic [DEN_W-1:0] den_r;

    always_comb begin
      num_nxt = num_w[s];
      quo_nxt = quo_w[s];
      rem_nxt = rem_w[s];
      for (int j = 0; j < DIV_STEP; j++) begin
        rem_nxt = {rem_nxt[DEN_W-1:0], num_nxt[DIV_W-1]};
        num_nxt = {num_nxt[DIV_W-2:0], 1'b0};
        if (rem_nxt >= {1'b0, den_w[s]}) begin
          rem_nxt = rem_nxt - {1'b0, den_w[s]};
          quo_nxt = {quo_nxt[DIV_W-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_nxt[DIV_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r <= num_nxt;
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        den_r <= den_w[s];
      end
    end

    assign num_w[s+1] = num_r;
    assign quo_w[s+1] = quo_r;
    assign rem_w[s+1] = rem_r;
    assign den_w[s+1] = den_r;
  end

  assign quo_out = quo_w[DIV_STAGES][PHASE_W-1:0];

endmodule

// File: src/rrpp_qsine.sv
module rrpp_qsine import rrpp_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [PHASE_W-1:0] p_in,
  output logic [15:0]        s_out
);

  logic [30:0] theta_r;
  logic [31:0] t2_r;
  logic [45:0] theta_prod;
  logic [61:0] sq_prod;

  logic [31:0]        term_w [N_TERMS+1];
  logic [31:0]        t2_w   [N_TERMS+1];
  logic signed [33:0] acc_w  [N_TERMS+1];

  assign theta_prod = p_in * HALF_PI_Q30;
  assign sq_prod    = theta_r * theta_r;

  always_ff @(posedge clk) begin
    if (en) begin
      theta_r <= theta_prod[44:14];
      t2_r    <= sq_prod[61:30];
    end
  end

  // term 0 (theta) lines up with t2 one stage later
  logic [30:0] theta_d_r;
  always_ff @(posedge clk) begin
    if (en) theta_d_r <= theta_r;
  end

  assign term_w[0] = {1'b0, theta_d_r};
  assign t2_w[0]   = t2_r;
  assign acc_w[0]  = '0;

  for (genvar k = 1; k <= N_TERMS; k++) begin : g_term
    localparam logic [7:0]  DK = 8'((2 * k) * (2 * k + 1));
    localparam logic [31:0] MK = 32'((64'd1 << 32) / ((2 * k) * (2 * k + 1)));

    logic [63:0]        mul_a, mul_b;
    logic [39:0]        mul_c;
    logic [31:0]        rem_c;
    logic [31:0]        x_a_r, x_b_r, qh_b_r, term_c_r;
    logic [31:0]        t2_a_r, t2_b_r, t2_c_r;
    logic signed [33:0] acc_nxt, acc_a_r, acc_b_r, acc_c_r;

    assign mul_a = term_w[k-1] * t2_w[k-1];
    assign mul_b = x_a_r * MK;
    assign mul_c = qh_b_r * DK;
    assign rem_c = x_b_r - mul_c[31:0];

    always_comb begin
      if ((k % 2) == 1) acc_nxt = acc_w[k-1] + $signed({2'b00, term_w[k-1]});
      else acc_nxt = acc_w[k-1] - $signed({2'b00, term_w[k-1]});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_a_r    <= mul_a[61:30];
        t2_a_r   <= t2_w[k-1];
        acc_a_r  <= acc_nxt;
        x_b_r    <= x_a_r;
        qh_b_r   <= mul_b[63:32];
        t2_b_r   <= t2_a_r;
        acc_b_r  <= acc_a_r;
        term_c_r <= qh_b_r + {31'd0, (rem_c >= {24'd0, DK})};
        t2_c_r   <= t2_b_r;
        acc_c_r  <= acc_b_r;
      end
    end

    assign term_w[k] = term_c_r;
    assign t2_w[k]   = t2_c_r;
    assign acc_w[k]  = acc_c_r;
  end

  logic signed [33:0] sum_r;
  logic [30:0]        clamp;
  logic [46:0]        scaled;
  logic [15:0]        s_r;

  always_comb begin
    if (sum_r < 0) clamp = '0;
    else if (sum_r > $signed({3'b000, ONE_Q30})) clamp = ONE_Q30;
    else clamp = sum_r[30:0];
  end

  assign scaled = clamp * TRIG_SCALE + 47'(ONE_Q30 >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= acc_w[N_TERMS] - $signed({2'b00, term_w[N_TERMS]});
      s_r   <= scaled[45:30];
    end
  end

  assign s_out = s_r;

endmodule

// File: src/rounded_rect_perimeter_point_unit.sv
// Returns the point on a rounded rectangle's outline reached at a given
// angle, walking clockwise from the top middle. One word is accepted per
// clock unless a result is stalled at the output; the depth is set
// by the 6-stage restoring divider for the arc angle and the 25-stage
// fixed-point sine series that runs for sine and cosine side by side. The
// whole pipeline advances together: it holds only while a finished result
// sits unread on the output, and then in_ready is low.
module rounded_rect_perimeter_point_unit import rrpp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [8:0]  in_rect_width,
  input  logic [8:0]  in_rect_height,
  input  logic [7:0]  in_corner_radius,
  input  logic signed [31:0] in_turn_angle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [9:0] out_point_x,
  output logic signed [9:0] out_point_y,
  output logic        out_bad_shape
);

  logic                en;
  logic [PIPE_LAT-1:0] vld_r;

  assign en        = !vld_r[PIPE_LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_valid};
    end
  end

  // stage 1: shape check, straight lengths
  logic [8:0]  dia;
  logic [17:0] p628;
  logic [8:0]  w1_r, h1_r, sh1_r, sv1_r;
  logic [7:0]  rad1_r;
  logic [15:0] ang1_r;
  logic        bad1_r;
  logic [17:0] p628_1_r;

  assign dia  = {in_corner_radius, 1'b0};
  assign p628 = in_corner_radius * ARC_SCALE;

  always_ff @(posedge clk) begin
    if (en) begin
      w1_r     <= in_rect_width;
      h1_r     <= in_rect_height;
      rad1_r   <= in_corner_radius;
      ang1_r   <= in_turn_angle[ANG_W-1:0];
      bad1_r   <= (in_corner_radius == '0) || (dia > in_rect_width) ||
                  (dia > in_rect_height);
      p628_1_r <= p628;
      sh1_r    <= in_rect_width - dia;
      sv1_r    <= in_rect_height - dia;
    end
  end

  // stage 2: arc length total, /100 by reciprocal
  logic [35:0] arc_prod;
  logic [10:0] arcs2_r;
  logic [8:0]  w2_r, h2_r, sh2_r, sv2_r;
  logic [7:0]  rad2_r;
  logic [15:0] ang2_r;
  logic        bad2_r;

  assign arc_prod = p628_1_r * RECIP_100;

  always_ff @(posedge clk) begin
    if (en) begin
      arcs2_r <= arc_prod[34:24];
      w2_r    <= w1_r;
      h2_r    <= h1_r;
      sh2_r   <= sh1_r;
      sv2_r   <= sv1_r;
      rad2_r  <= rad1_r;
      ang2_r  <= ang1_r;
      bad2_r  <= bad1_r;
    end
  end

  // stage 3: perimeter and quarter arc
  logic [11:0] per3_r;
  logic [8:0]  q3_r, w3_r, h3_r, sh3_r, sv3_r;
  logic [7:0]  rad3_r;
  logic [15:0] ang3_r;
  logic        bad3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      per3_r <= {2'b00, sh2_r, 1'b0} + {2'b00, sv2_r, 1'b0} + {1'b0, arcs2_r};
      q3_r   <= arcs2_r[10:2];
      w3_r   <= w2_r;
      h3_r   <= h2_r;
      sh3_r  <= sh2_r;
      sv3_r  <= sv2_r;
      rad3_r <= rad2_r;
      ang3_r <= ang2_r;
      bad3_r <= bad2_r;
    end
  end

  // stage 4: walked distance, segment ends
  logic [27:0] d_prod;
  logic [11:0] bnd [8];
  logic [11:0] d4_r;
  logic [11:0] bnd4_r [8];
  logic [8:0]  q4_r, w4_r, h4_r;
  logic [7:0]  rad4_r;
  logic        bad4_r;

  assign d_prod = ang3_r * per3_r;
  assign bnd[0] = {4'd0, sh3_r[8:1]};
  assign bnd[1] = bnd[0] + {3'd0, q3_r};
  assign bnd[2] = bnd[1] + {3'd0, sv3_r};
  assign bnd[3] = bnd[2] + {3'd0, q3_r};
  assign bnd[4] = bnd[3] + {3'd0, sh3_r};
  assign bnd[5] = bnd[4] + {3'd0, q3_r};
  assign bnd[6] = bnd[5] + {3'd0, sv3_r};
  assign bnd[7] = bnd[6] + {3'd0, q3_r};

  always_ff @(posedge clk) begin
    if (en) begin
      d4_r   <= d_prod[27:16];
      bnd4_r <= bnd;
      q4_r   <= q3_r;
      w4_r   <= w3_r;
      h4_r   <= h3_r;
      rad4_r <= rad3_r;
      bad4_r <= bad3_r;
    end
  end

  // stage 5: pick segment, straight point or arc corner
  seg_t        seg;
  logic [11:0] start, k;
  logic [9:0]  hw, hh, rr, k10;
  side_t       s5;
  side_t       s5_r;
  logic [8:0]  k5_r, q5_r;

  always_comb begin
    seg   = SEG_TOP_L;
    start = bnd4_r[7];
    for (int i = 7; i >= 0; i--) begin
      if (d4_r <= bnd4_r[i]) begin
        seg   = seg_t'(4'(i));
        start = (i == 0) ? 12'd0 : bnd4_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign k   = d4_r - start;
  assign k10 = k[9:0];
  assign hw  = {2'b00, w4_r[8:1]};
  assign hh  = {2'b00, h4_r[8:1]};
  assign rr  = {2'b00, rad4_r};

  always_comb begin
    s5.bad    = bad4_r;
    s5.rad    = rad4_r;
    s5.is_arc = 1'b0;
    s5.quad   = 2'd0;
    unique case (seg)
      SEG_TOP_R: begin
        s5.px = d4_r[9:0];
        s5.py = 10'd0 - hh;
      end
      ARC_TR: begin
        s5.is_arc = 1'b1;
        s5.px     = hw - rr;
        s5.py     = rr - hh;
      end
      SEG_RIGHT: begin
        s5.px = hw;
        s5.py = rr - hh + k10;
      end
      ARC_BR: begin
        s5.is_arc = 1'b1;
        s5.quad   = 2'd1;
        s5.px     = hw - rr;
        s5.py     = hh - rr;
      end
      SEG_BOTTOM: begin
        s5.px = hw - rr - k10;
        s5.py = hh;
      end
      ARC_BL: begin
        s5.is_arc = 1'b1;
        s5.quad   = 2'd2;
        s5.px     = rr - hw;
        s5.py     = hh - rr;
      end
      SEG_LEFT: begin
        s5.px = 10'd0 - hw;
        s5.py = hh - rr - k10;
      end
      ARC_TL: begin
        s5.is_arc = 1'b1;
        s5.quad   = 2'd3;
        s5.px     = rr - hw;
        s5.py     = rr - hh;
      end
      default: begin
        s5.px = rr - hw + k10;
        s5.py = 10'd0 - hh;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_r <= s5;
      k5_r <= k[8:0];
      q5_r <= q4_r;
    end
  end

  // arc angle within the corner: k * quarter turn / q
  logic [PHASE_W-1:0] phase;
  side_t              sd_r [DIV_STAGES];

  rrpp_div u_div (
    .clk     (clk),
    .en      (en),
    .num_in  ({1'b0, k5_r, 14'd0}),
    .den_in  (q5_r),
    .quo_out (phase)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= s5_r;
      for (int i = 1; i < DIV_STAGES; i++) sd_r[i] <= sd_r[i-1];
    end
  end

  // stage 6: full angle, quadrant and phase
  side_t              sdo, s6;
  logic [15:0]        a6;
  logic [PHASE_W-1:0] pa6_r, pb6_r;
  side_t              s6_r;

  assign sdo = sd_r[DIV_STAGES-1];
  assign a6  = {sdo.quad, 14'd0} + {1'b0, phase};

  always_comb begin
    s6      = sdo;
    s6.quad = a6[15:14];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa6_r <= {1'b0, a6[13:0]};
      pb6_r <= QTR_TURN - {1'b0, a6[13:0]};
      s6_r  <= s6;
    end
  end

  logic [15:0] sa, sb;
  side_t       qd_r [QS_LAT];

  rrpp_qsine u_sin_a (
    .clk   (clk),
    .en    (en),
    .p_in  (pa6_r),
    .s_out (sa)
  );

  rrpp_qsine u_sin_b (
    .clk   (clk),
    .en    (en),
    .p_in  (pb6_r),
    .s_out (sb)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      qd_r[0] <= s6_r;
      for (int i = 1; i < QS_LAT; i++) qd_r[i] <= qd_r[i-1];
    end
  end

  // E1: fold quadrant, scale by radius
  side_t       s7, e1_r;
  logic [15:0] smag, cmag;
  logic [23:0] mx1_r, my1_r;
  logic        sneg1_r, cneg1_r;

  assign s7   = qd_r[QS_LAT-1];
  assign smag = s7.quad[0] ? sb : sa;
  assign cmag = s7.quad[0] ? sa : sb;

  always_ff @(posedge clk) begin
    if (en) begin
      mx1_r   <= smag * s7.rad;
      my1_r   <= cmag * s7.rad;
      sneg1_r <= s7.quad[1];
      cneg1_r <= s7.quad[1] ^ s7.quad[0];
      e1_r    <= s7;
    end
  end

  // E2: divide by trig scale (truncating), add corner, output register
  logic [7:0]  qhx, qhy;
  logic [16:0] rmx, rmy;
  logic [9:0]  dvx, dvy, offx, offy, x_nxt, y_nxt;
  logic [9:0]  x_r, y_r;
  logic        bad_r;

  assign qhx  = mx1_r[23:16];
  assign qhy  = my1_r[23:16];
  assign rmx  = {1'b0, mx1_r[15:0]} + {9'd0, qhx};
  assign rmy  = {1'b0, my1_r[15:0]} + {9'd0, qhy};
  assign dvx  = {2'b00, qhx} + {9'd0, (rmx >= {1'b0, TRIG_SCALE})};
  assign dvy  = {2'b00, qhy} + {9'd0, (rmy >= {1'b0, TRIG_SCALE})};
  assign offx = sneg1_r ? (10'd0 - dvx) : dvx;
  assign offy = cneg1_r ? (10'd0 - dvy) : dvy;

  always_comb begin
    if (e1_r.bad) begin
      x_nxt = '0;
      y_nxt = '0;
    end else if (e1_r.is_arc) begin
      x_nxt = e1_r.px + offx;
      y_nxt = e1_r.py - offy;
    end else begin
      x_nxt = e1_r.px;
      y_nxt = e1_r.py;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      bad_r <= e1_r.bad;
    end
  end

  assign out_point_x   = x_r;
  assign out_point_y   = y_r;
  assign out_bad_shape = bad_r;

endmodule

// File: src/rrpp_checker.sv
module rrpp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [9:0] out_point_x,
  input logic [9:0] out_point_y,
  input logic       out_bad_shape
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_point_x) &&
    $stable(out_point_y) && $stable(out_bad_shape))
    else $error("stalled result word changed");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline is stalled");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_shape |-> out_point_x == '0 && out_point_y == '0)
    else $error("bad shape with nonzero point");

endmodule

bind rounded_rect_perimeter_point_unit rrpp_checker u_rrpp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_point_x   (out_point_x),
  .out_point_y   (out_point_y),
  .out_bad_shape (out_bad_shape)
);
